[hw/rtl/tsq_pkg.sv]
// Shared types and codes for the two-stack queue.
package tsq_pkg;

    // Request codes
    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // Capacity register width and value after reset
    localparam int          CAP_W     = 8;
    localparam logic [7:0]  CAP_RESET = 8'd128;

    // Width of the request and result value fields
    localparam int VALUE_W = 32;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_XFER = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

endpackage

[hw/rtl/tsq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/two_stack_queue.sv]
// Two-stack FIFO queue: top level with sequencer, stack counters and result register.
//
// A FIFO queue held in two stacks, each a single-port-pair RAM of DEPTH words.
// An add request (req_type 0) pushes value onto the input stack, or returns
// status full when that stack already holds min(capacity, DEPTH) entries. A
// get request (req_type 1) pops the output stack and returns the value with
// status ok; the word is read from the RAM, whose read port is registered,
// before S_RESP loads it into the result register. When the output stack is
// empty, a get first moves all n entries of the input stack across, one entry
// per cycle through the RAM read/write pipeline, and then pops the oldest
// entry; each entry moves at most once. A get with both stacks empty returns
// status empty. value_out is zero except on a successful get. One request is
// in flight at a time; a new request is taken as soon as the previous result
// sits in the output register, even if that result is still stalled. The capacity
// register (reset 128) may be written only while the queue is idle; lowering
// it below the current fill keeps the stored entries.
module two_stack_queue #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,

    // Request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic signed [31:0] value,

    // Result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic signed [31:0] value_out
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > tsq_pkg::CAP_W) ? CNT_W : tsq_pkg::CAP_W;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    // State and counters
    tsq_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] in_count_reg, in_count_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             xfer_pend_reg, xfer_pend_next;
    logic [7:0]       cap_reg;

    // Latched request
    logic                       req_type_reg;
    logic [tsq_pkg::VALUE_W-1:0] value_reg;

    // Result register
    logic                        rsp_valid_reg, rsp_valid_next;
    tsq_pkg::status_t            status_reg, status_next;
    logic [tsq_pkg::VALUE_W-1:0] value_out_reg, value_out_next;

    // RAM ports
    logic                  in_we, in_re, out_we, out_re;
    logic [ADDR_W-1:0]     in_waddr, in_raddr, out_waddr, out_raddr;
    logic [DATA_WIDTH-1:0] in_wdata, in_rdata, out_rdata;

    // Helpers
    logic [CNT_W-1:0] in_top, out_top, in_inc, out_inc;
    logic [CMP_W-1:0] in_cnt_cmp, cap_cmp;
    logic             in_full, slot_free, req_acc, rsp_load;
    logic [63:0]      value_ext, rdata_ext;

    assign in_top     = in_count_reg - 1'b1;
    assign out_top    = out_count_reg - 1'b1;
    assign in_inc     = in_count_reg + 1'b1;
    assign out_inc    = out_count_reg + 1'b1;
    assign in_cnt_cmp = CMP_W'(in_count_reg);
    assign cap_cmp    = CMP_W'(cap_reg);
    assign in_full    = (in_cnt_cmp >= cap_cmp) || (in_count_reg >= CNT_MAX);

    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg != tsq_pkg::S_IDLE);
    assign req_acc    = req_valid && !req_stall;

    // Stored words keep the low DATA_WIDTH bits; results show the low 32
    assign value_ext  = 64'(value_reg);
    assign in_wdata   = value_ext[DATA_WIDTH-1:0];
    assign rdata_ext  = 64'(out_rdata);

    // Input and output stacks
    tsq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    tsq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (in_rdata),
        .re    (out_re),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    // Sequencer and stack control
    always_comb
    begin
        state_next     = state_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        xfer_pend_next = xfer_pend_reg;
        in_we          = 1'b0;
        in_waddr       = in_count_reg[ADDR_W-1:0];
        in_re          = 1'b0;
        in_raddr       = in_top[ADDR_W-1:0];
        out_we         = 1'b0;
        out_waddr      = out_count_reg[ADDR_W-1:0];
        out_re         = 1'b0;
        out_raddr      = out_top[ADDR_W-1:0];
        rsp_load       = 1'b0;
        status_next    = tsq_pkg::ST_OK;
        value_out_next = '0;

        unique case (state_reg)
            tsq_pkg::S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = tsq_pkg::S_EXEC;
                end
            end

            tsq_pkg::S_EXEC:
            begin
                if (req_type_reg == tsq_pkg::REQ_ADD)
                begin
                    // Push, or report full
                    if (slot_free)
                    begin
                        rsp_load   = 1'b1;
                        state_next = tsq_pkg::S_IDLE;
                        if (in_full)
                        begin
                            status_next = tsq_pkg::ST_FULL;
                        end
                        else
                        begin
                            in_we         = 1'b1;
                            in_count_next = in_inc;
                        end
                    end
                end
                else if (out_count_reg != '0)
                begin
                    // Pop: read top of output stack
                    out_re         = 1'b1;
                    out_count_next = out_top;
                    state_next     = tsq_pkg::S_RESP;
                end
                else if (in_count_reg != '0)
                begin
                    xfer_pend_next = 1'b0;
                    state_next     = tsq_pkg::S_XFER;
                end
                else if (slot_free)
                begin
                    rsp_load    = 1'b1;
                    status_next = tsq_pkg::ST_EMPTY;
                    state_next  = tsq_pkg::S_IDLE;
                end
            end

            tsq_pkg::S_XFER:
            begin
                // Write the word read last cycle onto the output stack
                if (xfer_pend_reg)
                begin
                    out_we         = 1'b1;
                    out_count_next = out_inc;
                end
                // Read the next word off the input stack
                if (in_count_reg != '0)
                begin
                    in_re          = 1'b1;
                    in_count_next  = in_top;
                    xfer_pend_next = 1'b1;
                end
                else
                begin
                    xfer_pend_next = 1'b0;
                    if (!xfer_pend_reg)
                    begin
                        // Transfer done: pop the oldest entry
                        out_re         = 1'b1;
                        out_count_next = out_top;
                        state_next     = tsq_pkg::S_RESP;
                    end
                end
            end

            tsq_pkg::S_RESP:
            begin
                if (slot_free)
                begin
                    rsp_load       = 1'b1;
                    value_out_next = rdata_ext[tsq_pkg::VALUE_W-1:0];
                    state_next     = tsq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tsq_pkg::S_IDLE;
            end
        endcase
    end

    // Result valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsq_pkg::S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            xfer_pend_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cap_reg       <= tsq_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            xfer_pend_reg <= xfer_pend_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            req_type_reg <= req_type;
            value_reg    <= value;
        end
        if (rsp_load)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

    // Checks
    a_in_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_count_reg <= CNT_MAX)
        else $error("input stack count beyond depth");

    a_out_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= CNT_MAX)
        else $error("output stack count beyond depth");

    a_xfer_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsq_pkg::S_XFER && xfer_pend_reg) |-> (out_count_reg < CNT_MAX))
        else $error("transfer writes past the output stack");

    a_xfer_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsq_pkg::S_EXEC && state_next == tsq_pkg::S_XFER)
            |-> (out_count_reg == '0 && in_count_reg != '0))
        else $error("transfer started with a non-empty output stack");

    a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsq_pkg::S_RESP && $past(state_reg) != tsq_pkg::S_RESP)
            |-> ($past(state_reg) == tsq_pkg::S_EXEC || $past(state_reg) == tsq_pkg::S_XFER))
        else $error("pop result without a preceding read");

endmodule

[tb/sv/two_stack_queue_test.sv]
// Self-checking testbench for the two-stack queue: directed table, then random request phases.
module two_stack_queue_test;

    localparam int DEPTH    = 128;
    localparam int N_PHASES = 10;

    typedef struct packed {
        tsq_pkg::status_t st;
        logic [31:0]      val;
    } result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CAP
    } row_kind_t;

    // One row of the directed table; a capacity row carries the new value in val
    typedef struct {
        row_kind_t   kind;
        logic        rtype;
        logic [31:0] val;
        bit          typed;
        result_t     res;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [7:0]        cfg_data;
    logic              req_valid;
    logic              req_stall;
    logic              req_type;
    logic signed [31:0] value;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [1:0]        status;
    logic signed [31:0] value_out;

    // Typed expectation that travels with the request being offered
    logic              cur_typed;
    result_t           cur_res;

    // Queue shadow: two stacks, their counts and the capacity register
    logic [31:0]       in_stk [DEPTH];
    logic [31:0]       out_stk [DEPTH];
    int                in_cnt  = 0;
    int                out_cnt = 0;
    int                cap_reg = tsq_pkg::CAP_RESET;

    result_t           pending_q [$];
    row_t              dir_rows [$];

    int                errors      = 0;
    int                results_in  = 0;
    int                n_full      = 0;
    int                n_empty     = 0;
    int                n_popped    = 0;
    bit                quiet       = 1'b0;

    two_stack_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .value_out (value_out)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #3200000;
        $display("two_stack_queue_test: done, errors");
        $finish;
    end

    // Shadow of one request: updates the stacks and returns the result it yields
    function automatic result_t queue_step(input logic rtype, input logic [31:0] v);
        result_t r;
        int      lim;
        r.st  = tsq_pkg::ST_OK;
        r.val = '0;
        lim   = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        if (rtype == tsq_pkg::REQ_ADD)
        begin
            if (in_cnt >= lim)
                r.st = tsq_pkg::ST_FULL;
            else
            begin
                in_stk[in_cnt] = v;
                in_cnt++;
            end
        end
        else
        begin
            // refill the output stack only once it has run dry
            if (out_cnt == 0)
            begin
                while (in_cnt > 0 && out_cnt < DEPTH)
                begin
                    in_cnt--;
                    out_stk[out_cnt] = in_stk[in_cnt];
                    out_cnt++;
                end
            end
            if (out_cnt == 0)
                r.st = tsq_pkg::ST_EMPTY;
            else
            begin
                out_cnt--;
                r.val = out_stk[out_cnt];
            end
        end
        return r;
    endfunction

    function automatic row_t mk_row(input row_kind_t k, input logic rt, input logic [31:0] v,
                                    input bit typed, input tsq_pkg::status_t st,
                                    input logic [31:0] vo);
        row_t r;
        r.kind    = k;
        r.rtype   = rt;
        r.val     = v;
        r.typed   = typed;
        r.res.st  = st;
        r.res.val = vo;
        return r;
    endfunction

    // Request side: record the expected result of every accepted request
    always @(posedge clk)
    begin : req_mon
        result_t r;
        if (rst_n && req_valid && !req_stall)
        begin
            r = queue_step(req_type, value);
            if (req_type == tsq_pkg::REQ_GET && r.st == tsq_pkg::ST_OK)
                n_popped++;
            if (cur_typed)
                pending_q.push_back(cur_res);
            else
                pending_q.push_back(r);
        end
    end

    // Result side: compare against the oldest expectation
    always @(posedge clk)
    begin : rsp_mon
        result_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_in++;
            if (pending_q.size() == 0)
            begin
                $error("result with nothing expected: status %0d value_out %h", status, value_out);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    errors++;
                end
                if (value_out !== e.val)
                begin
                    $error("value_out: expected %h, got %h", e.val, value_out);
                    errors++;
                end
                case (e.st)
                    tsq_pkg::ST_FULL:  n_full++;
                    tsq_pkg::ST_EMPTY: n_empty++;
                    default:           ;
                endcase
            end
        end
    end

    // Receiver: random stall, plus two long hold-offs so the block backs up
    initial
    begin : receiver
        int holds;
        int n;
        holds     = 0;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ((holds == 0 && results_in >= 150) || (holds == 1 && results_in >= 900))
            begin
                holds++;
                rsp_stall <= 1'b1;
                for (n = 0; n < 200; n++)
                    @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= (!quiet && $urandom_range(0, 99) < 16);
        end
    end

    // Offer one request, with random idle cycles ahead of it; returns on a falling edge
    task automatic send_req(input logic rt, input logic [31:0] v,
                            input bit typed, input result_t res);
        while (!quiet && $urandom_range(0, 99) < 16)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rt;
        value     <= v;
        cur_typed <= typed;
        cur_res   <= res;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Let the queue go quiet, then write the capacity register
    task automatic set_capacity(input logic [7:0] c);
        req_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cap_reg  = c;
    endtask

    // Stimulus
    initial
    begin : stim
        logic [31:0] caps [N_PHASES];
        logic [31:0] extremes [4];
        logic [31:0] v;
        logic        rt;
        int          p;
        int          i;
        int          n_fill;
        int          n_drain;
        int          pct;
        int          pct_fill;
        int          pct_drain;
        int          wait_n;
        result_t     none;

        none      = '0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = tsq_pkg::CAP_RESET;
        req_valid = 1'b0;
        req_type  = tsq_pkg::REQ_ADD;
        value     = '0;
        cur_typed = 1'b0;
        cur_res   = '0;

        extremes[0] = 32'h7FFF_FFFF;
        extremes[1] = 32'h8000_0000;
        extremes[2] = 32'h0000_0000;
        extremes[3] = 32'hFFFF_FFFF;

        // Directed table: reset capacity, then zero, one, a drop below the fill
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         1,
                                  tsq_pkg::ST_EMPTY, 32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h7FFF_FFFF, 1,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h8000_0000, 1,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h0000_0000, 1,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'hFFFF_FFFF, 1,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'hFFFF_FFFF, 1,
                                  tsq_pkg::ST_OK,    32'h7FFF_FFFF));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h0000_0005, 0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         1,
                                  tsq_pkg::ST_OK,    32'h8000_0000));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         1,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         1,
                                  tsq_pkg::ST_OK,    32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         1,
                                  tsq_pkg::ST_EMPTY, 32'h0));
        // capacity zero: every add is refused
        dir_rows.push_back(mk_row(ROW_CAP, tsq_pkg::REQ_ADD, 32'd0,         0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'hA5A5_A5A5, 1,
                                  tsq_pkg::ST_FULL,  32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         1,
                                  tsq_pkg::ST_EMPTY, 32'h0));
        // capacity one: full on the input side while the output stack has room
        dir_rows.push_back(mk_row(ROW_CAP, tsq_pkg::REQ_ADD, 32'd1,         0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h1234_5678, 1,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h5A5A_5A5A, 1,
                                  tsq_pkg::ST_FULL,  32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         0,
                                  tsq_pkg::ST_OK,    32'h0));
        // fill four, then drop the capacity below the fill
        dir_rows.push_back(mk_row(ROW_CAP, tsq_pkg::REQ_ADD, 32'd128,       0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h0000_0011, 0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'hC0DE_0022, 0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h3333_0033, 0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'hF00D_0044, 0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_CAP, tsq_pkg::REQ_ADD, 32'd2,         0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h0000_0055, 1,
                                  tsq_pkg::ST_FULL,  32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_ADD, 32'h0000_0066, 0,
                                  tsq_pkg::ST_OK,    32'h0));
        dir_rows.push_back(mk_row(ROW_REQ, tsq_pkg::REQ_GET, 32'h0,         0,
                                  tsq_pkg::ST_OK,    32'h0));

        // Reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CAP)
                set_capacity(dir_rows[i].val[7:0]);
            else
                send_req(dir_rows[i].rtype, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random phases: capacity above depth, extremes and a few random settings
        caps[0] = 255;
        caps[1] = 1;
        caps[2] = 128;
        caps[3] = 0;
        caps[4] = $urandom_range(3, 127);
        caps[5] = 64;
        caps[6] = $urandom_range(0, 255);
        caps[7] = 2;
        caps[8] = 128;
        caps[9] = $urandom_range(129, 254);

        for (p = 0; p < N_PHASES; p++)
        begin
            set_capacity(caps[p][7:0]);
            quiet = (p == 4 || p == 5);
            // first phase offers adds past the stack depth, then drains it all
            if (p == 0)
            begin
                n_fill    = 140;
                pct_fill  = 100;
                n_drain   = 140;
                pct_drain = 0;
            end
            else
            begin
                n_fill    = 60;
                pct_fill  = 80;
                n_drain   = 60;
                pct_drain = 25;
            end
            for (i = 0; i < n_fill + n_drain; i++)
            begin
                pct = (i < n_fill) ? pct_fill : pct_drain;
                rt  = ($urandom_range(0, 99) < pct) ? tsq_pkg::REQ_ADD : tsq_pkg::REQ_GET;
                v   = $urandom;
                if ($urandom_range(0, 7) == 0)
                    v = extremes[$urandom_range(0, 3)];
                send_req(rt, v, 1'b0, none);
            end
        end
        quiet = 1'b0;

        // Drain and finish
        req_valid <= 1'b0;
        wait_n = 0;
        while (pending_q.size() != 0 && wait_n < 100000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (20) @(posedge clk);
        if (pending_q.size() != 0)
        begin
            $error("%0d results never arrived", pending_q.size());
            errors++;
        end
        $display("%0d results seen over %0d capacity settings: %0d popped, %0d full, %0d empty",
                 results_in, N_PHASES + 4, n_popped, n_full, n_empty);
        if (errors == 0)
            $display("two_stack_queue_test: done, clean");
        else
            $display("two_stack_queue_test: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_ram.sv
hw/rtl/two_stack_queue.sv
tb/sv/two_stack_queue_test.sv
